### hw/rtl/vcs_pkg.sv
// ----------------------------------------------------------------------------
// vcs_pkg
// Widths and limits shared by the cosine similarity datapath and its
// finishing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vcs_pkg;

  // running sums
  localparam int DOT_W  = 42;
  localparam int NORM_W = 41;
  localparam int COS_W  = 16;

  // finishing unit: squared products, quotient and root
  localparam int WIDE_W = 2 * DOT_W;
  localparam int ALU_W  = WIDE_W + 1;
  localparam int QUO_W  = 2 * (COS_W - 1);
  localparam int ROOT_W = QUO_W / 2;
  localparam int CNT_W  = $clog2(DOT_W);

  localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  localparam logic signed [COS_W-1:0] COS_POS_MAX = {1'b0, {(COS_W-1){1'b1}}};
  localparam logic signed [COS_W-1:0] COS_NEG_MAX = {1'b1, {(COS_W-1){1'b0}}};

endpackage

`default_nettype wire

### hw/rtl/vector_cosine_similarity.sv
// ----------------------------------------------------------------------------
// vector_cosine_similarity
// Accumulates dot product and both squared norms over a stream of element
// pairs and reports the Q1.15 cosine and raw dot product per vector pair.
// ----------------------------------------------------------------------------
// Each element pair passes ST_IDLE, ST_MUL_AB, ST_MUL_AA, ST_MUL_BB and
// ST_ACC_BB: one signed multiplier is shared for a*b, a*a and b*b, each
// product registered before its saturating add. The pair marked last then
// passes ST_CHECK and, unless a norm is zero, the finishing unit, whose
// single 85-bit add/subtract runs two 42-step multiplies, a compare that
// may saturate the result, a 30-step divide and a 15-step square root. A
// result sits in the output register until taken while the next vector's
// first pair is accepted; a new result waits for it to drain. Sums saturate.
`default_nettype none

module vector_cosine_similarity #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ELEMENT_BITS-1:0]      in_elem_a,
  input  logic signed [ELEMENT_BITS-1:0]      in_elem_b,
  input  logic                                in_last_element,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vcs_pkg::COS_W-1:0]    out_cosine,
  output logic signed [vcs_pkg::DOT_W-1:0]    out_dot_product,
  output logic                                out_zero_norm
);

  localparam int DOT_W   = vcs_pkg::DOT_W;
  localparam int NORM_W  = vcs_pkg::NORM_W;
  localparam int COS_W   = vcs_pkg::COS_W;
  localparam int PROD_W  = 2 * ELEMENT_BITS;
  localparam int SUM_W   = ((PROD_W > DOT_W) ? PROD_W : DOT_W) + 1;
  localparam int NSUM_W  = ((PROD_W > NORM_W) ? PROD_W : NORM_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_ACC_BB,
    ST_CHECK,
    ST_FINISH,
    ST_WAIT_OUT
  } state_t;

  state_t                        state_r, state_nxt;
  logic signed [ELEMENT_BITS-1:0] a_r, a_nxt;
  logic signed [ELEMENT_BITS-1:0] b_r, b_nxt;
  logic                          last_r, last_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic [DOT_W-1:0]              dot_r, dot_nxt;
  logic [NORM_W-1:0]             na_r, na_nxt;
  logic [NORM_W-1:0]             nb_r, nb_nxt;
  logic                          zero_r, zero_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [COS_W-1:0]       out_cos_r, out_cos_nxt;
  logic [DOT_W-1:0]              out_dot_r, out_dot_nxt;
  logic                          out_zero_r, out_zero_nxt;

  logic signed [ELEMENT_BITS-1:0] mul_x, mul_y;
  logic signed [PROD_W-1:0]      mul_p;
  logic [SUM_W-1:0]              dot_add;
  logic [DOT_W-1:0]              dot_sat;
  logic [NSUM_W-1:0]             na_add, nb_add;
  logic [NORM_W-1:0]             na_sat, nb_sat;
  logic                          cos_start;
  logic                          cos_done;
  logic signed [COS_W-1:0]       cos_val;

  // shared element multiplier
  always_comb begin
    mul_x = a_r;
    mul_y = b_r;
    case (state_r)
      ST_MUL_AA: begin
        mul_y = a_r;
      end
      ST_MUL_BB: begin
        mul_x = b_r;
      end
      default: begin
        mul_x = a_r;
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  // saturating accumulation of the registered product
  always_comb begin
    dot_add = {{(SUM_W-DOT_W){dot_r[DOT_W-1]}}, dot_r}
            + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if ((&dot_add[SUM_W-1:DOT_W-1]) || !(|dot_add[SUM_W-1:DOT_W-1])) begin
      dot_sat = dot_add[DOT_W-1:0];
    end else begin
      dot_sat = dot_add[SUM_W-1] ? vcs_pkg::DOT_MIN : vcs_pkg::DOT_MAX;
    end

    na_add = {{(NSUM_W-NORM_W){1'b0}}, na_r} + {{(NSUM_W-PROD_W){1'b0}}, prod_r};
    nb_add = {{(NSUM_W-NORM_W){1'b0}}, nb_r} + {{(NSUM_W-PROD_W){1'b0}}, prod_r};
    na_sat = (|na_add[NSUM_W-1:NORM_W]) ? vcs_pkg::NORM_MAX : na_add[NORM_W-1:0];
    nb_sat = (|nb_add[NSUM_W-1:NORM_W]) ? vcs_pkg::NORM_MAX : nb_add[NORM_W-1:0];
  end

  assign cos_start = (state_r == ST_CHECK) && (na_r != '0) && (nb_r != '0);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    dot_nxt       = dot_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cos_nxt   = out_cos_r;
    out_dot_nxt   = out_dot_r;
    out_zero_nxt  = out_zero_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt     = in_elem_a;
          b_nxt     = in_elem_b;
          last_nxt  = in_last_element;
          state_nxt = ST_MUL_AB;
        end
      end
      ST_MUL_AB: begin
        state_nxt = ST_MUL_AA;
      end
      ST_MUL_AA: begin
        dot_nxt   = dot_sat;
        state_nxt = ST_MUL_BB;
      end
      ST_MUL_BB: begin
        na_nxt    = na_sat;
        state_nxt = ST_ACC_BB;
      end
      ST_ACC_BB: begin
        nb_nxt    = nb_sat;
        state_nxt = last_r ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        zero_nxt  = !cos_start;
        state_nxt = cos_start ? ST_FINISH : ST_WAIT_OUT;
      end
      ST_FINISH: begin
        if (cos_done) begin
          state_nxt = ST_WAIT_OUT;
        end
      end
      ST_WAIT_OUT: begin
        // load once the output register drains, then clear the sums
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cos_nxt   = zero_r ? '0 : cos_val;
          out_dot_nxt   = dot_r;
          out_zero_nxt  = zero_r;
          dot_nxt       = '0;
          na_nxt        = '0;
          nb_nxt        = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dot_r       <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dot_r       <= dot_nxt;
      na_r        <= na_nxt;
      nb_r        <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    prod_r     <= mul_p;
    zero_r     <= zero_nxt;
    out_cos_r  <= out_cos_nxt;
    out_dot_r  <= out_dot_nxt;
    out_zero_r <= out_zero_nxt;
  end

  vcs_cos_unit u_cos (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cos_start),
    .dot    (dot_r),
    .norm_a (na_r),
    .norm_b (nb_r),
    .done   (cos_done),
    .cosine (cos_val)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cosine      = out_cos_r;
  assign out_dot_product = out_dot_r;
  assign out_zero_norm   = out_zero_r;

endmodule

`default_nettype wire

### hw/rtl/vcs_cos_unit.sv
// ----------------------------------------------------------------------------
// vcs_cos_unit
// Iterative cosine finisher: one shared add/subtract unit runs shift-add
// multiplies for dot^2 and norm_a*norm_b, a saturation compare, a restoring
// divide and a restoring square root, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vcs_cos_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [vcs_pkg::DOT_W-1:0]    dot,
  input  logic        [vcs_pkg::NORM_W-1:0]   norm_a,
  input  logic        [vcs_pkg::NORM_W-1:0]   norm_b,
  output logic                                done,
  output logic signed [vcs_pkg::COS_W-1:0]    cosine
);

  localparam int DOT_W  = vcs_pkg::DOT_W;
  localparam int NORM_W = vcs_pkg::NORM_W;
  localparam int COS_W  = vcs_pkg::COS_W;
  localparam int WIDE_W = vcs_pkg::WIDE_W;
  localparam int ALU_W  = vcs_pkg::ALU_W;
  localparam int QUO_W  = vcs_pkg::QUO_W;
  localparam int ROOT_W = vcs_pkg::ROOT_W;
  localparam int CNT_W  = vcs_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_D,
    S_MUL_P,
    S_CMP,
    S_DIV,
    S_SQRT
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      neg_r, neg_nxt;
  logic [DOT_W-1:0]          mplier_r, mplier_nxt;
  logic [WIDE_W-1:0]         mcand_r, mcand_nxt;
  logic [WIDE_W-1:0]         acc_r, acc_nxt;
  logic [WIDE_W-1:0]         sq_r, sq_nxt;
  logic [WIDE_W-1:0]         prod_r, prod_nxt;
  logic [WIDE_W-1:0]         rem_r, rem_nxt;
  logic [NORM_W-1:0]         na_r, na_nxt;
  logic [NORM_W-1:0]         nb_r, nb_nxt;
  logic [QUO_W-1:0]          quot_r, quot_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic signed [COS_W-1:0]   cos_r, cos_nxt;

  logic [DOT_W-1:0]          mag;
  logic [ALU_W-1:0]          alu_a, alu_b, alu_s;
  logic                      alu_sub;
  logic                      alu_ge;
  logic [COS_W-1:0]          root_ext;

  assign mag = dot[DOT_W-1] ? (~dot + 1'b1) : dot;

  // shared adder; on subtract the top bit is the borrow
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_MUL_D, S_MUL_P: begin
        alu_a = {1'b0, acc_r};
        alu_b = mplier_r[0] ? {1'b0, mcand_r} : '0;
      end
      S_CMP: begin
        alu_a   = {1'b0, sq_r};
        alu_b   = {1'b0, prod_r};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {1'b0, rem_r[WIDE_W-2:0], 1'b0};
        alu_b   = {1'b0, prod_r};
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_a   = {1'b0, rem_r[WIDE_W-3:0], quot_r[QUO_W-1:QUO_W-2]};
        alu_b   = {1'b0, {(WIDE_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_s  = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_W-1){1'b0}}, alu_sub};
    alu_ge = ~alu_s[ALU_W-1];
  end

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    mplier_nxt = mplier_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    sq_nxt     = sq_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    na_nxt     = na_r;
    nb_nxt     = nb_r;
    quot_nxt   = quot_r;
    root_nxt   = root_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    cos_nxt    = cos_r;
    root_ext   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt    = dot[DOT_W-1];
          mplier_nxt = mag;
          mcand_nxt  = {{(WIDE_W-DOT_W){1'b0}}, mag};
          acc_nxt    = '0;
          na_nxt     = norm_a;
          nb_nxt     = norm_b;
          cnt_nxt    = CNT_W'(DOT_W - 1);
          state_nxt  = S_MUL_D;
        end
      end

      S_MUL_D, S_MUL_P: begin
        acc_nxt    = alu_s[WIDE_W-1:0];
        mcand_nxt  = {mcand_r[WIDE_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[DOT_W-1:1]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          acc_nxt = '0;
          cnt_nxt = CNT_W'(DOT_W - 1);
          if (state_r == S_MUL_D) begin
            sq_nxt     = alu_s[WIDE_W-1:0];
            mplier_nxt = {{(DOT_W-NORM_W){1'b0}}, na_r};
            mcand_nxt  = {{(WIDE_W-NORM_W){1'b0}}, nb_r};
            state_nxt  = S_MUL_P;
          end else begin
            prod_nxt  = alu_s[WIDE_W-1:0];
            state_nxt = S_CMP;
          end
        end
      end

      S_CMP: begin
        // dot^2 >= norm product means the magnitude reaches one
        if (alu_ge) begin
          cos_nxt   = neg_r ? vcs_pkg::COS_NEG_MAX : vcs_pkg::COS_POS_MAX;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rem_nxt   = sq_r;
          quot_nxt  = '0;
          cnt_nxt   = CNT_W'(QUO_W - 1);
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt  = alu_ge ? alu_s[WIDE_W-1:0] : alu_a[WIDE_W-1:0];
        quot_nxt = {quot_r[QUO_W-2:0], alu_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          state_nxt = S_SQRT;
        end
      end

      S_SQRT: begin
        rem_nxt  = alu_ge ? alu_s[WIDE_W-1:0] : alu_a[WIDE_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], alu_ge};
        quot_nxt = {quot_r[QUO_W-3:0], 2'b00};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          root_ext  = {1'b0, root_nxt};
          cos_nxt   = neg_r ? (~root_ext + 1'b1) : root_ext;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    neg_r    <= neg_nxt;
    mplier_r <= mplier_nxt;
    mcand_r  <= mcand_nxt;
    acc_r    <= acc_nxt;
    sq_r     <= sq_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    na_r     <= na_nxt;
    nb_r     <= nb_nxt;
    quot_r   <= quot_nxt;
    root_r   <= root_nxt;
    cnt_r    <= cnt_nxt;
    cos_r    <= cos_nxt;
  end

  assign done   = done_r;
  assign cosine = cos_r;

endmodule

`default_nettype wire

### sim/vector_cosine_similarity_test.sv
// ----------------------------------------------------------------------------
// vector_cosine_similarity_test
// Streams element pairs into the cosine similarity block and checks every
// result beat (cosine, dot product, zero-norm flag) against a bit-exact
// predictor or a typed directed row's values. A directed table covers
// extremes and the zero-norm case, then random vectors of mixed shape and
// length, three long runs of extreme elements that build large sums and a
// quiet phase follow. Both handshakes stall in bursts, but not when quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_cosine_similarity_test;

  localparam int ELEM_W         = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1175;
  localparam int QUIET_ITEMS    = 300;
  localparam int RUN_LENGTH     = 150;
  localparam int DRAIN_CYCLES   = 300;
  localparam int NUM_DIRECTED   = 25;

  typedef logic signed [ELEM_W-1:0]          elem_t;
  typedef logic signed [vcs_pkg::COS_W-1:0]  cos_t;
  typedef logic signed [vcs_pkg::DOT_W-1:0]  dot_t;
  typedef logic        [vcs_pkg::NORM_W-1:0] norm_t;

  typedef struct packed {
    cos_t cosine;
    dot_t dot;
    logic zero_norm;
  } similarity_t;

  typedef struct packed {
    elem_t       a;
    elem_t       b;
    logic        last;
    logic        typed;
    similarity_t want;
  } pair_row_t;

  typedef enum int {
    MIX_RANDOM,
    MIX_EXTREME,
    MIX_SMALL,
    MIX_SAME,
    MIX_OPPOSITE,
    MIX_NEAR,
    MIX_ZERO_A,
    MIX_ZERO_B,
    MIX_COUNT
  } mix_t;

  localparam logic signed [vcs_pkg::DOT_W:0] DOT_HI = $signed({1'b0, vcs_pkg::DOT_MAX});
  localparam logic signed [vcs_pkg::DOT_W:0] DOT_LO = $signed({1'b1, vcs_pkg::DOT_MIN});

  // a, b, last, typed, {cosine, dot, zero_norm}; untyped rows use the predictor
  localparam pair_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{16'sd0,      16'sd0,      1'b1, 1'b1, '{16'sd0,      42'sd0,           1'b1}},
    '{16'sh7FFF,   16'sh7FFF,   1'b1, 1'b1, '{16'sh7FFF,   42'sd1073676289,  1'b0}},
    '{16'sh8000,   16'sh8000,   1'b1, 1'b1, '{16'sh7FFF,   42'sd1073741824,  1'b0}},
    '{16'sh8000,   16'sh7FFF,   1'b1, 1'b1, '{16'sh8000,  -42'sd1073709056,  1'b0}},
    '{16'sh7FFF,   16'sh8000,   1'b1, 1'b1, '{16'sh8000,  -42'sd1073709056,  1'b0}},
    '{16'sd1,      16'sd0,      1'b1, 1'b1, '{16'sd0,      42'sd0,           1'b1}},
    '{16'sd0,     -16'sd1,      1'b1, 1'b1, '{16'sd0,      42'sd0,           1'b1}},
    '{16'sh1234,   16'sd0,      1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd0,      16'sh4321,   1'b1, 1'b1, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd1,      16'sd1,      1'b1, 1'b1, '{16'sh7FFF,   42'sd1,           1'b0}},
    '{16'sd1,     -16'sd1,      1'b1, 1'b1, '{16'sh8000,  -42'sd1,           1'b0}},
    '{16'sd3,      16'sd4,      1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd4,     -16'sd3,      1'b1, 1'b1, '{16'sd0,      42'sd0,           1'b0}},
    '{-16'sd1,    -16'sd1,      1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd0,      16'sd0,      1'b1, 1'b1, '{16'sh7FFF,   42'sd1,           1'b0}},
    '{16'sd100,    16'sd200,    1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{-16'sd300,   16'sd50,     1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd7,     -16'sd9,      1'b1, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sh5555,   16'shAAAA,   1'b1, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'shAAAA,   16'sh5555,   1'b1, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd12345, -16'sd6789,   1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sh8000,   16'sh7FFF,   1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sh7FFF,   16'sd1000,   1'b1, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd0,      16'sd0,      1'b0, 1'b0, '{16'sd0,      42'sd0,           1'b0}},
    '{16'sd0,      16'sd0,      1'b1, 1'b1, '{16'sd0,      42'sd0,           1'b1}}
  };

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  elem_t in_elem_a;
  elem_t in_elem_b;
  logic  in_last_element;
  logic  out_valid;
  logic  out_ready;
  cos_t  out_cosine;
  dot_t  out_dot_product;
  logic  out_zero_norm;

  vector_cosine_similarity #(
    .ELEMENT_BITS(ELEM_W)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_elem_a       (in_elem_a),
    .in_elem_b       (in_elem_b),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cosine      (out_cosine),
    .out_dot_product (out_dot_product),
    .out_zero_norm   (out_zero_norm)
  );

  // predictor state
  dot_t        dot_acc;
  norm_t       norm_a_acc;
  norm_t       norm_b_acc;
  similarity_t pending_results [$];

  bit idle_on;
  int errors;
  int items_sent;
  int vectors_sent;
  int results_seen;
  int zero_norm_seen;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Largest m with m^2 * na * nb <= dot^2 * 2^30, signed and clamped to Q1.15.
  function automatic cos_t cosine_q15(dot_t dot, norm_t na, norm_t nb);
    logic [vcs_pkg::DOT_W-1:0] mag;
    logic [127:0] rhs;
    logic [127:0] prod;
    logic [127:0] cc;
    logic [15:0]  m;
    logic [15:0]  c;
    int           k;
    mag  = dot[vcs_pkg::DOT_W-1] ? -dot : dot;
    rhs  = 128'(mag);
    rhs  = (rhs * rhs) << 30;
    prod = 128'(na) * 128'(nb);
    m    = '0;
    for (k = 15; k >= 0; k--) begin
      c  = m | (16'd1 << k);
      cc = 128'(c);
      cc = cc * cc;
      if (prod * cc <= rhs)
        m = c;
    end
    if (dot[vcs_pkg::DOT_W-1]) begin
      if (m > 16'd32768)
        m = 16'd32768;
      return cos_t'(16'd0 - m);
    end
    if (m > 16'd32767)
      m = 16'd32767;
    return cos_t'(m);
  endfunction

  // Fold one pair into the sums; on the last pair return the result and clear.
  function automatic bit advance_sums(elem_t a, elem_t b, logic last, output similarity_t r);
    logic signed [31:0]              p;
    logic        [31:0]              sqa;
    logic        [31:0]              sqb;
    logic signed [vcs_pkg::DOT_W:0]  d;
    logic        [vcs_pkg::NORM_W:0] sa;
    logic        [vcs_pkg::NORM_W:0] sb;
    r   = '0;
    p   = a * b;
    sqa = a * a;
    sqb = b * b;
    d   = dot_acc + p;
    if (d > DOT_HI)
      d = DOT_HI;
    if (d < DOT_LO)
      d = DOT_LO;
    dot_acc = d[vcs_pkg::DOT_W-1:0];
    sa = norm_a_acc + sqa;
    sb = norm_b_acc + sqb;
    norm_a_acc = (sa > {1'b0, vcs_pkg::NORM_MAX}) ? vcs_pkg::NORM_MAX : sa[vcs_pkg::NORM_W-1:0];
    norm_b_acc = (sb > {1'b0, vcs_pkg::NORM_MAX}) ? vcs_pkg::NORM_MAX : sb[vcs_pkg::NORM_W-1:0];
    if (!last)
      return 1'b0;
    if (norm_a_acc == '0 || norm_b_acc == '0)
      r = '{cos_t'(0), dot_acc, 1'b1};
    else
      r = '{cosine_q15(dot_acc, norm_a_acc, norm_b_acc), dot_acc, 1'b0};
    dot_acc    = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    return 1'b1;
  endfunction

  // Entered and left at a falling edge; holds the beat until accepted.
  task automatic send_pair(elem_t a, elem_t b, logic last, logic typed, similarity_t want);
    similarity_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_elem_a       = a;
    in_elem_b       = b;
    in_last_element = last;
    in_valid        = 1'b1;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    if (advance_sums(a, b, last, predicted))
      pending_results = {pending_results, (typed ? want : predicted)};
    items_sent++;
    @(negedge clk);
  endtask

  function automatic elem_t extreme_elem();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sh7FFF;
    endcase
  endfunction

  task automatic send_vector(int len, mix_t mix);
    elem_t a;
    elem_t b;
    int    i;
    for (i = 0; i < len; i++) begin
      a = elem_t'($urandom());
      b = elem_t'($urandom());
      case (mix)
        MIX_EXTREME: begin
          a = extreme_elem();
          b = extreme_elem();
        end
        MIX_SMALL: begin
          a = elem_t'($urandom_range(0, 16)) - 16'sd8;
          b = elem_t'($urandom_range(0, 16)) - 16'sd8;
        end
        MIX_SAME:     b = a;
        MIX_OPPOSITE: b = -a;
        MIX_NEAR:     b = a + elem_t'($urandom_range(0, 128)) - 16'sd64;
        MIX_ZERO_A:   a = '0;
        MIX_ZERO_B:   b = '0;
        default: ;
      endcase
      send_pair(a, b, i == len - 1, 1'b0, '0);
    end
    vectors_sent++;
  endtask

  // Long run of fixed elements, b alternating, to build large sums.
  task automatic send_run(elem_t a, elem_t b0, elem_t b1, int len);
    int i;
    for (i = 0; i < len; i++)
      send_pair(a, i[0] ? b1 : b0, i == len - 1, 1'b0, '0);
    vectors_sent++;
  endtask

  task automatic check_result();
    similarity_t exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected: cosine %0d, dot %0d, zero_norm %0b",
               $time, $signed(out_cosine), $signed(out_dot_product), out_zero_norm);
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    results_seen++;
    if (out_zero_norm === 1'b1)
      zero_norm_seen++;
    if (exp_r.cosine !== out_cosine) begin
      $display("%0t: cosine mismatch: expected %0d, actual %0d",
               $time, $signed(exp_r.cosine), $signed(out_cosine));
      errors++;
    end
    if (exp_r.dot !== out_dot_product) begin
      $display("%0t: dot_product mismatch: expected %0d, actual %0d",
               $time, $signed(exp_r.dot), $signed(out_dot_product));
      errors++;
    end
    if (exp_r.zero_norm !== out_zero_norm) begin
      $display("%0t: zero_norm mismatch: expected %0b, actual %0b",
               $time, exp_r.zero_norm, out_zero_norm);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      check_result();
  end

  // Result side: stall in bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0)
        stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 10);
      out_ready = (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    pair_row_t row;
    int        k;
    int        target;
    int        pick;
    int        len;
    in_valid        = 1'b0;
    in_elem_a       = '0;
    in_elem_b       = '0;
    in_last_element = 1'b0;
    rst_n           = 1'b0;
    idle_on         = 1'b1;
    errors          = 0;
    items_sent      = 0;
    vectors_sent    = 0;
    results_seen    = 0;
    zero_norm_seen  = 0;
    dot_acc         = '0;
    norm_a_acc      = '0;
    norm_b_acc      = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < NUM_DIRECTED; k++) begin
      row = DIRECTED_ROWS[k];
      send_pair(row.a, row.b, row.last, row.typed, row.want);
    end

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 9);
      if (pick < 6)
        len = $urandom_range(1, 8);
      else if (pick < 9)
        len = $urandom_range(9, 40);
      else
        len = $urandom_range(41, 200);
      send_vector(len, mix_t'($urandom_range(0, int'(MIX_COUNT) - 1)));
    end

    // large positive dot, large negative dot, and big norms with a small dot
    idle_on = 1'b1;
    send_run(16'sh8000, 16'sh8000, 16'sh8000, RUN_LENGTH);
    send_run(16'sh8000, 16'sh7FFF, 16'sh7FFF, RUN_LENGTH);
    send_run(16'sh8000, 16'sh7FFF, 16'sh8000, RUN_LENGTH);

    idle_on = 1'b0;
    target  = items_sent + QUIET_ITEMS;
    while (items_sent < target)
      send_vector($urandom_range(1, 12), mix_t'($urandom_range(0, int'(MIX_COUNT) - 1)));
    in_valid = 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d element pairs in %0d vectors, including three long extreme runs.",
             items_sent, vectors_sent);
    $display("Checked %0d results, %0d of them zero-norm; %0d mismatches.",
             results_seen, zero_norm_seen, errors);
    if (errors == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
